[sv/rcps_pkg.sv]
// Shared types, constants and helper functions for the raycast column pixel shader.
// No dependencies; every other file of the block imports this package.
package rcps_pkg;

    // Screen and texture geometry
    localparam int SCREEN_HEIGHT = 512;
    localparam int SCREEN_WIDTH  = 1024;
    localparam int TEXTURE_SIZE  = 64;

    // Field widths
    localparam int ROW_W    = 9;
    localparam int COL_W    = 10;
    localparam int SPAN_W   = 10;
    localparam int HEIGHT_W = 16;
    localparam int TCOL_W   = 6;
    localparam int TADDR_W  = 14;
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 19;
    localparam int TROW_W   = $clog2(TEXTURE_SIZE);
    localparam int TEX_ID_W = TADDR_W - 2 * TROW_W;
    localparam int TEX_DEPTH = 2 ** TADDR_W;

    // Texel row arithmetic: signed half-pixel offset, its halved magnitude and the
    // numerator of the fraction (distance times texture size)
    localparam int SUM_W = HEIGHT_W + 2;
    localparam int D_W   = HEIGHT_W;
    localparam int NUM_W = D_W + TROW_W;
    localparam int REM_W = HEIGHT_W;

    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXTURED_MODE,
        CFG_SKY_COLOR,
        CFG_FLOOR_COLOR,
        CFG_COLOR_X_POSITIVE,
        CFG_COLOR_X_NEGATIVE,
        CFG_COLOR_Y_POSITIVE,
        CFG_COLOR_Y_NEGATIVE
    } cfg_reg_t;

    localparam logic [COLOR_W-1:0] SKY_COLOR_RST   = 24'h00C8FF;
    localparam logic [COLOR_W-1:0] FLOOR_COLOR_RST = 24'hB38B6D;
    localparam logic [COLOR_W-1:0] X_POS_COLOR_RST = 24'hFF0000;
    localparam logic [COLOR_W-1:0] X_NEG_COLOR_RST = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] Y_POS_COLOR_RST = 24'hFF00FF;
    localparam logic [COLOR_W-1:0] Y_NEG_COLOR_RST = 24'h0000FF;

    // Request kinds
    localparam logic REQ_SHADE = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    column;
        logic [SPAN_W-1:0]   draw_start;
        logic [SPAN_W-1:0]   draw_end;
        logic [HEIGHT_W-1:0] wall_height;
        logic [TCOL_W-1:0]   tex_column;
        logic                wall_axis;
        logic                step_sign;
        logic [TADDR_W-1:0]  texel_address;
        logic [COLOR_W-1:0]  texel_color;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
    } pix_t;

    typedef struct packed {
        logic               textured_mode;
        logic [COLOR_W-1:0] sky_color;
        logic [COLOR_W-1:0] floor_color;
        logic [COLOR_W-1:0] color_x_positive;
        logic [COLOR_W-1:0] color_x_negative;
        logic [COLOR_W-1:0] color_y_positive;
        logic [COLOR_W-1:0] color_y_negative;
    } cfg_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic                is_write;
        logic                use_tex;
        logic [COLOR_W-1:0]  color;
        logic [ADDR_W-1:0]   pixel_address;
        logic [D_W-1:0]      half_offset;
        logic [HEIGHT_W-1:0] height;
        logic [TEX_ID_W-1:0] tex_id;
        logic [TCOL_W-1:0]   tex_column;
        logic [TADDR_W-1:0]  texel_address;
        logic [COLOR_W-1:0]  texel_color;
    } work_t;

    // One divider stage: item plus partial remainder, remaining numerator bits and
    // the low quotient bits collected so far
    typedef struct packed {
        work_t              item;
        logic [REM_W-1:0]   rem;
        logic [NUM_W-1:0]   num;
        logic [TROW_W-1:0]  quo;
    } div_t;

    // x/positive -> 3, x/negative -> 1, y/positive -> 2, y/negative -> 0
    function automatic logic [TEX_ID_W-1:0] tex_id_of(input logic axis, input logic sign);
        return {sign, ~axis};
    endfunction

    // One restoring division step on the next numerator bit
    function automatic div_t div_step(input div_t s);
        logic [REM_W:0] trial;
        logic [REM_W:0] divisor;
        logic           fits;
        div_t           r;
        r       = s;
        trial   = {s.rem, s.num[NUM_W-1]};
        divisor = {1'b0, s.item.height};
        fits    = (trial >= divisor);
        r.rem   = fits ? REM_W'(trial - divisor) : REM_W'(trial);
        r.num   = {s.num[NUM_W-2:0], 1'b0};
        r.quo   = {s.quo[TROW_W-2:0], fits};
        return r;
    endfunction

endpackage

[sv/rcps_front.sv]
// Front end: accepts requests, classifies them and forms the queue entry.
// Depends on rcps_pkg.
module rcps_front
    import rcps_pkg::*;
(
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    input  cfg_t  cfg,
    input  logic  queue_full,
    output logic  push,
    output work_t push_item
);

    logic [SUM_W-1:0]   twice;
    logic [SUM_W-1:0]   magn;
    logic               in_floor;
    logic               in_sky;
    logic [COLOR_W-1:0] flat_color;

    // Accept whenever the queue has room
    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

    // Half-pixel offset from the wall centre, then its halved magnitude
    assign twice = SUM_W'({req.row, 1'b0}) + SUM_W'(req.wall_height) - SUM_W'(SCREEN_HEIGHT);
    assign magn  = twice[SUM_W-1] ? (~twice + 1'b1) : twice;

    // Region of the column
    assign in_floor = ({1'b0, req.row} >= req.draw_end);
    assign in_sky   = ({1'b0, req.row} < req.draw_start);

    // Flat wall colour by axis and step sign
    always_comb
    begin
        case ({req.wall_axis, req.step_sign})
            2'b00:   flat_color = cfg.color_x_negative;
            2'b01:   flat_color = cfg.color_x_positive;
            2'b10:   flat_color = cfg.color_y_negative;
            2'b11:   flat_color = cfg.color_y_positive;
            default: flat_color = cfg.color_x_negative;
        endcase
    end

    // Build the queue entry
    always_comb
    begin
        push_item.is_write      = (req.req_type == REQ_WRITE);
        push_item.use_tex       = !in_floor && !in_sky && cfg.textured_mode;
        push_item.color         = in_floor ? cfg.floor_color :
                                  in_sky   ? cfg.sky_color   : flat_color;
        push_item.pixel_address = ADDR_W'(req.row) * ADDR_W'(SCREEN_WIDTH)
                                + ADDR_W'(req.column);
        push_item.half_offset   = magn[D_W:1];
        push_item.height        = req.wall_height;
        push_item.tex_id        = tex_id_of(req.wall_axis, req.step_sign);
        push_item.tex_column    = req.tex_column;
        push_item.texel_address = req.texel_address;
        push_item.texel_color   = req.texel_color;
    end

endmodule

[sv/rcps_queue.sv]
// Short queue between the front and back ends of the shader.
// Depends on rcps_pkg.
module rcps_queue
    import rcps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output work_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

[sv/rcps_back.sv]
// Back end: pipelined texel row divider, texture memory and output register.
// Depends on rcps_pkg.
module rcps_back
    import rcps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  work_t head,
    output logic  pop,
    output logic  pix_valid,
    input  logic  pix_stall,
    output pix_t  pix
);

    localparam int LAST = NUM_W - 1;

    div_t               div_reg   [NUM_W];
    div_t               div_next  [NUM_W];
    logic [NUM_W-1:0]   div_valid_reg;
    div_t               entry;
    logic               pipe_adv;
    logic [TROW_W-1:0]  tex_row;
    logic [TADDR_W-1:0] rd_addr;
    logic [COLOR_W-1:0] tex_mem [TEX_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    work_t              mem_item_reg;
    logic               mem_valid_reg;
    logic               pix_valid_reg;
    pix_t               pix_reg;

    // The whole pipeline moves unless a finished pixel is held at the output
    assign pipe_adv = !(pix_valid_reg && pix_stall);
    assign pop      = pipe_adv && head_valid;

    // Numerator is distance times texture size
    always_comb
    begin
        entry.item = head;
        entry.rem  = '0;
        entry.num  = {head.half_offset, {TROW_W{1'b0}}};
        entry.quo  = '0;
    end

    // One division step per stage
    always_comb
    begin
        div_next[0] = div_step(entry);
        for (int k = 1; k < NUM_W; k++)
        begin
            div_next[k] = div_step(div_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            mem_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            div_valid_reg <= {div_valid_reg[NUM_W-2:0], pop};
            mem_valid_reg <= div_valid_reg[LAST] && !div_reg[LAST].item.is_write;
            pix_valid_reg <= mem_valid_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Zero wall height gives texel row zero
    assign tex_row = (div_reg[LAST].item.height == '0) ? '0 : div_reg[LAST].quo;
    assign rd_addr = {div_reg[LAST].item.tex_id, tex_row, div_reg[LAST].item.tex_column};

    // Texture memory: writes and reads take place in order at the same stage
    always_ff @(posedge clk)
    begin
        if (pipe_adv && div_valid_reg[LAST])
        begin
            if (div_reg[LAST].item.is_write)
            begin
                tex_mem[div_reg[LAST].item.texel_address] <= div_reg[LAST].item.texel_color;
            end
            else
            begin
                rd_data_reg <= tex_mem[rd_addr];
            end
        end
    end

    // Hold item beside the read data, then pick the final colour
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            mem_item_reg          <= div_reg[LAST].item;
            pix_reg.pixel_address <= mem_item_reg.pixel_address;
            pix_reg.pixel_color   <= mem_item_reg.use_tex ? rd_data_reg : mem_item_reg.color;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_adv |=> ($stable(div_valid_reg) && $stable(mem_valid_reg)))
        else $error("pipeline moved while output held");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_adv && div_valid_reg[LAST] && div_reg[LAST].item.is_write) |=> !mem_valid_reg)
        else $error("texel write turned into a pixel");

endmodule

[sv/raycast_column_pixel_shader.sv]
// Raycast column pixel shader: shades one wall-column pixel per request and gives its
// frame buffer address; texel-write requests fill four 64x64 textures and give no result.
// Throughput is one request per clock, sustained, for shades and texel writes alike, while the
// pixel output is not stalled. A shaded pixel passes through the pipelined restoring divider
// that forms the texel row (one numerator bit per stage), then the texture memory read
// register and the output register. A four-entry queue sits between the request side and the
// pixel pipeline, so a stalled pixel output fills the queue before the request side sees
// stall. Texture memory has no reset; read only written texels. Write configuration registers
// only while the block is idle.
// Depends on rcps_pkg, rcps_front, rcps_queue and rcps_back.
module raycast_column_pixel_shader
    import rcps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output pix_t                  pix,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  queue_full;
    logic  push;
    work_t push_item;
    logic  pop;
    logic  head_valid;
    work_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.textured_mode    <= 1'b1;
            cfg_reg.sky_color        <= SKY_COLOR_RST;
            cfg_reg.floor_color      <= FLOOR_COLOR_RST;
            cfg_reg.color_x_positive <= X_POS_COLOR_RST;
            cfg_reg.color_x_negative <= X_NEG_COLOR_RST;
            cfg_reg.color_y_positive <= Y_POS_COLOR_RST;
            cfg_reg.color_y_negative <= Y_NEG_COLOR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_TEXTURED_MODE:    cfg_reg.textured_mode    <= cfg_data[0];
                CFG_SKY_COLOR:        cfg_reg.sky_color        <= cfg_data;
                CFG_FLOOR_COLOR:      cfg_reg.floor_color      <= cfg_data;
                CFG_COLOR_X_POSITIVE: cfg_reg.color_x_positive <= cfg_data;
                CFG_COLOR_X_NEGATIVE: cfg_reg.color_x_negative <= cfg_data;
                CFG_COLOR_Y_POSITIVE: cfg_reg.color_y_positive <= cfg_data;
                CFG_COLOR_Y_NEGATIVE: cfg_reg.color_y_negative <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcps_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    rcps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    rcps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

endmodule
